// ----- rtl/debounced_input_event_fifo_macros.svh -----
// Assertion macros for the debounced input event FIFO.
// Used by the port checker; no other dependencies.
`ifndef DEBOUNCED_INPUT_EVENT_FIFO_MACROS_SVH
`define DEBOUNCED_INPUT_EVENT_FIFO_MACROS_SVH

// same-cycle implication
`define DIEF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DIEF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dief_pkg.sv -----
// Shared types and constants of the debounced input event FIFO.
// No dependencies.
`default_nettype none

package dief_pkg;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_RELEASE = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int DEBOUNCE_WIDTH = 8;
   localparam logic CSR_IDX_DEBOUNCE = 1'b0;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 8'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] code;
      logic       pressed_level;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/dief_req_if.sv -----
// Request channel interface: scan ticks and read commands.
// Standalone; no package dependency.
`default_nettype none

interface dief_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic pin_level;

   modport source (output valid, output mode, output pin_level, input ready);
   modport sink   (input valid, input mode, input pin_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/dief_rsp_if.sv -----
// Response channel interface: event code and debounced level.
// Standalone; no package dependency.
`default_nettype none

interface dief_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_code;
   logic       pressed_level;

   modport source (output valid, output event_code, output pressed_level, input ready);
   modport sink   (input valid, input event_code, input pressed_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/debounced_input_event_fifo.sv -----
// A request word passes through the queue and then the response register before its
// response can be accepted (later while the response side stalls).
// Throughput: one word per cycle while the queue is not full; the two-entry queue and
// response register let the request side keep going while a response waits.
// Reset (synchronous) clears debouncer, pointers, queue and all ring entries;
// debounce_count returns to 3.
`default_nettype none

module debounced_input_event_fifo #(
   parameter int RING_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dief_req_if.sink                             req_chan,
   dief_rsp_if.source                           rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dief_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [dief_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [dief_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);
   import dief_pkg::*;

   logic [DEBOUNCE_WIDTH-1:0] debounce_count_ff;
   logic                      csr_write;
   logic                      csr_hit;
   logic                      q_push, q_pop, q_full, q_empty;
   entry_type                 q_in_entry, q_out_entry;

   assign pready    = 1'b1;
   assign csr_hit   = paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_DEBOUNCE;
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? CSR_DATA_WIDTH'(debounce_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_count_ff <= DEBOUNCE_RESET;
      end else if (csr_write) begin
         debounce_count_ff <= pwdata[DEBOUNCE_WIDTH-1:0];
      end
   end

   dief_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .debounce_count (debounce_count_ff),
      .queue_full     (q_full),
      .push           (q_push),
      .entry          (q_in_entry)
   );

   dief_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .pop_entry  (q_out_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   dief_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .head        (q_out_entry),
      .pop         (q_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- rtl/dief_front.sv -----
// Front end: accepts request words, runs the debouncer, emits ring operations.
// Depends on dief_pkg and dief_req_if.
`default_nettype none

module dief_front (
   input  logic                  clock,
   input  logic                  reset,
   dief_req_if.sink              req_chan,
   input  logic [7:0]            debounce_count,
   input  logic                  queue_full,
   output logic                  push,
   output dief_pkg::entry_type   entry
);
   import dief_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PRESS_Q,
      PH_PRESSED,
      PH_RELEASE_Q
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic       low;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign low            = !req_chan.pin_level;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      entry.op   = OP_NONE;
      entry.code = EV_NONE;
      if (!req_chan.mode) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (low) begin
                  count_in = debounce_count;
                  phase_in = PH_PRESS_Q;
               end
            end
            PH_PRESS_Q: begin
               if (!low) begin
                  phase_in = PH_IDLE;
               end else if (count_ff != 8'd0) begin
                  count_in = count_ff - 8'd1;
               end else begin
                  phase_in   = PH_PRESSED;
                  entry.op   = OP_PUSH;
                  entry.code = EV_PRESS;
               end
            end
            PH_PRESSED: begin
               if (!low) begin
                  count_in = debounce_count;
                  phase_in = PH_RELEASE_Q;
               end
            end
            PH_RELEASE_Q: begin
               if (low) begin
                  phase_in = PH_IDLE;
               end else if (count_ff != 8'd0) begin
                  count_in = count_ff - 8'd1;
               end else begin
                  phase_in   = PH_IDLE;
                  entry.op   = OP_PUSH;
                  entry.code = EV_RELEASE;
               end
            end
         endcase
      end else begin
         entry.op = OP_READ;
      end
      entry.pressed_level = (phase_in == PH_PRESSED) || (phase_in == PH_RELEASE_Q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 8'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dief_queue.sv -----
// Short operation queue between front and back end.
// Depends on dief_pkg.
`default_nettype none

module dief_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dief_pkg::entry_type push_entry,
   input  logic                pop,
   output dief_pkg::entry_type pop_entry,
   output logic                full,
   output logic                empty
);
   import dief_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      priority if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dief_back.sv -----
// Back end: event ring, write/read pointers and the response register.
// Depends on dief_pkg and dief_rsp_if.
`default_nettype none

module dief_back #(
   parameter int RING_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  dief_pkg::entry_type head,
   output logic                pop,
   dief_rsp_if.source          rsp_chan
);
   import dief_pkg::*;

   // non power-of-two depths collapse to a single entry
   localparam bit IS_POW2   = (RING_DEPTH & (RING_DEPTH - 1)) == 0;
   localparam int RING_USED = IS_POW2 ? RING_DEPTH : 1;
   localparam int PTR_W     = (RING_USED > 1) ? $clog2(RING_USED) : 1;

   logic [1:0]       ring_ff [RING_USED];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       code_ff, code_in;
   logic             level_ff, level_in;
   logic [1:0]       read_code;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_USED - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop       = !queue_empty && (!rsp_valid_ff || rsp_chan.ready);
   assign read_code = ring_ff[rd_ptr_ff];

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.event_code    = code_ff;
   assign rsp_chan.pressed_level = level_ff;

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      level_in     = level_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         level_in     = head.pressed_level;
         code_in      = EV_NONE;
         unique case (head.op)
            OP_PUSH: begin
               wr_ptr_in = next_ptr(wr_ptr_ff);
            end
            OP_READ: begin
               code_in = read_code;
               if (read_code != EV_NONE) begin
                  rd_ptr_in = next_ptr(rd_ptr_ff);
               end
            end
            default: begin
            end
         endcase
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RING_USED; i++) begin
            ring_ff[i] <= EV_NONE;
         end
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop && (head.op == OP_PUSH)) begin
            ring_ff[wr_ptr_ff] <= head.code;
         end else if (pop && (head.op == OP_READ) && (read_code != EV_NONE)) begin
            ring_ff[rd_ptr_ff] <= EV_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      level_ff <= level_in;
   end

endmodule

`default_nettype wire

// ----- rtl/dief_checker.sv -----
// Port-level checker for the debounced input event FIFO, bound to the top.
// Depends on debounced_input_event_fifo_macros.svh.
`default_nettype none
`include "debounced_input_event_fifo_macros.svh"

module dief_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event_code,
   input logic       rsp_pressed_level
);

   `DIEF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_code) && $stable(rsp_pressed_level), "response word changed while stalled")
   `DIEF_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "response word without accepted request")
   `DIEF_ASSERT_IMP(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "response valid right after reset")

endmodule

bind debounced_input_event_fifo dief_checker u_dief_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_event_code    (rsp_chan.event_code),
   .rsp_pressed_level (rsp_chan.pressed_level)
);

`default_nettype wire

// ----- verif/debounced_input_event_fifo_tb.sv -----
// Testbench for debounced_input_event_fifo: scan and read words are driven in
// directed and random runs, and every response word is checked against a local
// model of the debouncer and its event ring. Needs dief_pkg, dief_req_if, dief_rsp_if.
`timescale 1ns / 100ps

module debounced_input_event_fifo_tb;
   import dief_pkg::*;

   localparam int RING_DEPTH = 16;
   localparam logic [3:0] RING_MASK =
      (RING_DEPTH == 1 || RING_DEPTH == 2 || RING_DEPTH == 4 || RING_DEPTH == 8 ||
       RING_DEPTH == 16) ? 4'(RING_DEPTH - 1) : 4'd0;
   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_READ = 1'b1;
   localparam logic PIN_LOW   = 1'b0;
   localparam logic PIN_HIGH  = 1'b1;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_DEBOUNCE = {CSR_IDX_DEBOUNCE, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNUSED   = {~CSR_IDX_DEBOUNCE, 2'b00};
   localparam int LONG_HOLD = 40;

   typedef enum logic [1:0] {DB_IDLE, DB_ARMING, DB_HELD, DB_RELEASING} db_phase_type;

   typedef struct packed {
      logic mode;
      logic pin;
   } sample_word_type;

   typedef struct packed {
      logic [1:0] code;
      logic       level;
   } status_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_mode  = 1'b0;
   logic req_pin   = 1'b1;
   logic rsp_ready = 1'b0;

   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   dief_req_if req_bus();
   dief_rsp_if rsp_bus();

   assign req_bus.valid     = req_valid;
   assign req_bus.mode      = req_mode;
   assign req_bus.pin_level = req_pin;
   assign rsp_bus.ready     = rsp_ready;

   debounced_input_event_fifo #(.RING_DEPTH(RING_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // local copy of debouncer and ring
   logic [7:0]   debounce_cfg = DEBOUNCE_RESET;
   db_phase_type db_phase;
   logic [7:0]   db_count;
   logic [1:0]   ring [16];
   logic [3:0]   wr_ptr;
   logic [3:0]   rd_ptr;

   sample_word_type sample_queue[$];
   status_word_type status_due[$];
   sample_word_type next_sample;
   status_word_type seen_word;
   status_word_type due_word;

   int  mismatches = 0;
   int  accepted_words = 0;
   int  presses_logged = 0;
   int  releases_logged = 0;
   int  bounces = 0;
   int  overwrites = 0;
   int  empty_reads = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  holds_requested = 0;
   int  holds_served = 0;
   bit  idling_on = 1'b1;

   task automatic report_mismatch(input string what, input int seen, input int want);
      mismatches++;
      $display("[%0t] mismatch: %s got %0d, expected %0d", $realtime, what, seen, want);
   endtask

   task automatic log_event(input logic [1:0] code);
      if (ring[wr_ptr] != EV_NONE) overwrites++;
      ring[wr_ptr] = code;
      wr_ptr = (wr_ptr + 4'd1) & RING_MASK;
      if (code == EV_PRESS) presses_logged++;
      else releases_logged++;
   endtask

   task automatic advance_debouncer(input logic mode, input logic pin,
                                    output status_word_type word);
      logic low;
      low = (pin == PIN_LOW);
      word.code = EV_NONE;
      if (mode == MODE_READ) begin
         if (ring[rd_ptr] != EV_NONE) begin
            word.code = ring[rd_ptr];
            ring[rd_ptr] = EV_NONE;
            rd_ptr = (rd_ptr + 4'd1) & RING_MASK;
         end else begin
            empty_reads++;
         end
      end else begin
         case (db_phase)
            DB_IDLE: begin
               if (low) begin
                  db_count = debounce_cfg;
                  db_phase = DB_ARMING;
               end
            end
            DB_ARMING: begin
               if (!low) begin
                  db_phase = DB_IDLE;
                  bounces++;
               end else if (db_count != 8'd0) begin
                  db_count = db_count - 8'd1;
               end else begin
                  db_phase = DB_HELD;
                  log_event(EV_PRESS);
               end
            end
            DB_HELD: begin
               if (!low) begin
                  db_phase = DB_RELEASING;
                  db_count = debounce_cfg;
               end
            end
            default: begin
               if (low) begin
                  db_phase = DB_IDLE;
                  bounces++;
               end else if (db_count != 8'd0) begin
                  db_count = db_count - 8'd1;
               end else begin
                  db_phase = DB_IDLE;
                  log_event(EV_RELEASE);
               end
            end
         endcase
      end
      word.level = (db_phase == DB_HELD || db_phase == DB_RELEASING);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            next_sample = sample_queue.pop_front();
            req_valid <= 1'b1;
            req_mode  <= next_sample.mode;
            req_pin   <= next_sample.pin;
            if (idling_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_requested > holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idling_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 5);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         db_phase = DB_IDLE;
         db_count = 8'd0;
         wr_ptr = 4'd0;
         rd_ptr = 4'd0;
         for (int i = 0; i < 16; i++) ring[i] = EV_NONE;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            advance_debouncer(req_bus.mode, req_bus.pin_level, seen_word);
            status_due.push_back(seen_word);
            accepted_words++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (status_due.size() == 0) begin
               report_mismatch("unexpected response word, event_code", rsp_bus.event_code,
                               EV_NONE);
            end else begin
               due_word = status_due.pop_front();
               if (rsp_bus.event_code !== due_word.code)
                  report_mismatch("event_code", rsp_bus.event_code, due_word.code);
               if (rsp_bus.pressed_level !== due_word.level)
                  report_mismatch("pressed_level", rsp_bus.pressed_level, due_word.level);
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_DEBOUNCE) debounce_cfg = data[7:0];
   endtask

   task automatic csr_check(input logic [7:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= ADDR_DEBOUNCE;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {{(CSR_DATA_WIDTH-8){1'b0}}, want})
         report_mismatch("debounce_count readback", prdata, want);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic queue_scans(input logic level, input int count);
      for (int i = 0; i < count; i++) sample_queue.push_back('{MODE_SCAN, level});
   endtask

   task automatic queue_reads(input int count);
      for (int i = 0; i < count; i++)
         sample_queue.push_back('{MODE_READ, 1'($urandom_range(0, 1))});
   endtask

   // mostly steady runs long enough to qualify, some short bounces, some reads
   task automatic queue_random_burst(input int count, input int read_pct);
      int added;
      int kind;
      int run;
      logic level;
      added = 0;
      level = PIN_HIGH;
      while (added < count) begin
         kind = $urandom_range(0, 99);
         if (kind < read_pct) begin
            run = $urandom_range(1, 4);
            queue_reads(run);
         end else if (kind < read_pct + (100 - read_pct) * 7 / 10) begin
            level = ~level;
            run = int'(debounce_cfg) + 2 + $urandom_range(0, 2);
            queue_scans(level, run);
         end else begin
            run = $urandom_range(1, int'(debounce_cfg) + 1);
            queue_scans(1'($urandom_range(0, 1)), run);
         end
         added += run;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || status_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [CSR_DATA_WIDTH-1:0] cfg_word;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      csr_check(DEBOUNCE_RESET);

      // default count of 3: empty read, press, release, both bounce kinds
      @(negedge clock);
      queue_reads(1);
      queue_scans(PIN_LOW, 5);
      queue_reads(2);
      queue_scans(PIN_HIGH, 5);
      queue_reads(2);
      queue_scans(PIN_LOW, 2);
      queue_scans(PIN_HIGH, 1);
      queue_scans(PIN_LOW, 5);
      queue_scans(PIN_HIGH, 2);
      queue_scans(PIN_LOW, 1);
      queue_reads(2);
      wait_drained();

      // zero count, few reads so the ring wraps and overwrites
      cfg_word = $urandom();
      cfg_word[7:0] = 8'd0;
      csr_write(ADDR_DEBOUNCE, cfg_word);
      csr_check(debounce_cfg);
      @(negedge clock);
      queue_random_burst(80, 5);
      queue_reads(20);
      wait_drained();

      // maximum count: one full press, then a release bounce and a press bounce
      cfg_word = $urandom();
      cfg_word[7:0] = 8'hFF;
      csr_write(ADDR_DEBOUNCE, cfg_word);
      csr_check(debounce_cfg);
      @(negedge clock);
      queue_scans(PIN_LOW, 257);
      queue_reads(1);
      queue_scans(PIN_HIGH, 4);
      queue_scans(PIN_LOW, 3);
      queue_scans(PIN_HIGH, 1);
      queue_reads(2);
      wait_drained();

      // small counts, long response stall while requests keep coming
      cfg_word = $urandom();
      cfg_word[7:0] = 8'($urandom_range(1, 5));
      csr_write(ADDR_DEBOUNCE, cfg_word);
      csr_write(ADDR_UNUSED, $urandom());
      csr_check(debounce_cfg);
      @(negedge clock);
      queue_random_burst(90, 30);
      holds_requested++;
      wait_drained();

      // closing stretch without idling
      cfg_word = $urandom();
      cfg_word[7:0] = 8'($urandom_range(0, 3));
      csr_write(ADDR_DEBOUNCE, cfg_word);
      csr_check(debounce_cfg);
      @(negedge clock);
      idling_on = 1'b0;
      queue_random_burst(60, 30);
      wait_drained();
      repeat (6) @(negedge clock);

      if (status_due.size() != 0)
         report_mismatch("words still outstanding", status_due.size(), 0);
      $display("covered %0d words: %0d presses and %0d releases logged, %0d bounces",
               accepted_words, presses_logged, releases_logged, bounces);
      $display("%0d ring overwrites, %0d reads of an empty slot, counts 0 through 255",
               overwrites, empty_reads);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule
